// ----- rtl/core/ialu_pkg.sv -----
// Shared types and constants of the integer ALU: item structs, operation
// and status codes, and the control word that travels down the pipeline.
// No dependencies.
package ialu_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_DIVU  = 5'd4;
  localparam logic [4:0] OP_REM   = 5'd5;
  localparam logic [4:0] OP_REMU  = 5'd6;
  localparam logic [4:0] OP_AND   = 5'd7;
  localparam logic [4:0] OP_OR    = 5'd8;
  localparam logic [4:0] OP_XOR   = 5'd9;
  localparam logic [4:0] OP_NOR   = 5'd10;
  localparam logic [4:0] OP_SLL   = 5'd11;
  localparam logic [4:0] OP_SRL   = 5'd12;
  localparam logic [4:0] OP_SRA   = 5'd13;
  localparam logic [4:0] OP_SLT   = 5'd14;
  localparam logic [4:0] OP_SLTU  = 5'd15;
  localparam logic [4:0] OP_MOV   = 5'd16;
  localparam logic [4:0] OP_MULH  = 5'd17;
  localparam logic [4:0] OP_MULHU = 5'd18;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIV0    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [5:0] SHIFT_MASK = 6'h3F;

  typedef struct packed {
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [4:0]  req_type;
  } req_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
  } rsp_item_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] op;
    logic [1:0] status;
    logic       neg_q;
    logic       neg_r;
  } ctrl_t;

endpackage

// ----- rtl/core/ialu_prep.sv -----
// First pipeline stage: operand masking, the add, logic, shift, compare and move
// operations and the setup of divider magnitudes and signs. Depends on ialu_pkg.
module ialu_prep import ialu_pkg::*; #(
  parameter int W = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid,
  input  req_item_t     req_item,
  output ctrl_t         ctrl,
  output logic [W-1:0]  a_out,
  output logic [W-1:0]  b_out,
  output logic [W-1:0]  side,
  output logic [W-1:0]  dvd,
  output logic [W-1:0]  dsr
);

  logic [W-1:0] a, b, ma, mb, side_next, dvd_next, dsr_next;
  logic [5:0]   amt;
  logic [4:0]   op;
  logic         an, bn, nq, nr;
  logic [1:0]   st;

  always_comb begin
    a   = req_item.operand_a[W-1:0];
    b   = req_item.operand_b[W-1:0];
    op  = req_item.req_type;
    amt = req_item.operand_b[5:0] & SHIFT_MASK;
    an  = a[W-1];
    bn  = b[W-1];
    ma  = an ? (~a + 1'b1) : a;
    mb  = bn ? (~b + 1'b1) : b;
    side_next = '0;
    dvd_next  = a;
    dsr_next  = b;
    nq = 1'b0;
    nr = 1'b0;
    st = ST_OK;
    case (op) inside
      OP_ADD:  side_next = a + b;
      OP_SUB:  side_next = a - b;
      OP_AND:  side_next = a & b;
      OP_OR:   side_next = a | b;
      OP_XOR:  side_next = a ^ b;
      OP_NOR:  side_next = ~(a | b);
      OP_SLL:  side_next = a << amt;
      OP_SRL:  side_next = a >> amt;
      OP_SRA:  side_next = $signed(a) >>> amt;
      OP_SLT:  side_next = {{(W-1){1'b0}}, ($signed(a) < $signed(b))};
      OP_SLTU: side_next = {{(W-1){1'b0}}, (a < b)};
      OP_MOV:  side_next = a;
      OP_MUL, OP_MULH, OP_MULHU: side_next = '0;
      OP_DIV, OP_REM: begin
        dvd_next = ma;
        dsr_next = mb;
        nq = an ^ bn;
        nr = an;
        if (b == '0) st = ST_DIV0;
      end
      OP_DIVU, OP_REMU: begin
        if (b == '0) st = ST_DIV0;
      end
      default: st = ST_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl.op     <= op;
      ctrl.status <= st;
      ctrl.neg_q  <= nq;
      ctrl.neg_r  <= nr;
      a_out       <= a;
      b_out       <= b;
      side        <= side_next;
      dvd         <= dvd_next;
      dsr         <= dsr_next;
    end
  end

endmodule

// ----- rtl/core/ialu_mul.sv -----
// Three-stage multiplier: half-width partial products, their sum, and the
// selection of low half, unsigned or signed high half. Depends on ialu_pkg.
module ialu_mul import ialu_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         en,
  input  logic [4:0]   op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] result
);

  localparam int H = (W + 1) / 2;

  logic [H-1:0]   al, ah, bl, bh;
  logic [2*H-1:0] p0, p1, p2, p3;
  logic [4*H-1:0] sum;
  logic [2*W-1:0] prod;
  logic [W-1:0]   a1, b1, a2, b2, hi, res_next;
  logic [4:0]     op1, op2;

  always_comb begin
    al = a[H-1:0];
    ah = H'(a >> H);
    bl = b[H-1:0];
    bh = H'(b >> H);
  end

  always_comb begin
    sum = (4*H)'(p0) + ((4*H)'(p1) << H) + ((4*H)'(p2) << H) + ((4*H)'(p3) << (2*H));
  end

  always_comb begin
    hi = prod[2*W-1:W];
    case (op2)
      OP_MUL:   res_next = prod[W-1:0];
      OP_MULHU: res_next = hi;
      OP_MULH:  res_next = hi - (a2[W-1] ? b2 : '0) - (b2[W-1] ? a2 : '0);
      default:  res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0     <= al * bl;
      p1     <= al * bh;
      p2     <= ah * bl;
      p3     <= ah * bh;
      a1     <= a;
      b1     <= b;
      op1    <= op;
      prod   <= sum[2*W-1:0];
      a2     <= a1;
      b2     <= b1;
      op2    <= op1;
      result <= res_next;
    end
  end

endmodule

// ----- rtl/core/ialu_div_step.sv -----
// One restoring division step as a pipeline stage; it also carries the
// control word and the side result of other operations. Depends on ialu_pkg.
module ialu_div_step import ialu_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  ctrl_t        ctrl_in,
  input  logic [W-1:0] side_in,
  input  logic [W-1:0] rem_in,
  input  logic [W-1:0] quo_in,
  input  logic [W-1:0] dsr_in,
  output ctrl_t        ctrl_out,
  output logic [W-1:0] side_out,
  output logic [W-1:0] rem_out,
  output logic [W-1:0] quo_out,
  output logic [W-1:0] dsr_out
);

  logic [W:0] t, diff;
  logic       ge;

  always_comb begin
    t    = {rem_in, quo_in[W-1]};
    diff = t - {1'b0, dsr_in};
    ge   = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_out.op     <= ctrl_in.op;
      ctrl_out.status <= ctrl_in.status;
      ctrl_out.neg_q  <= ctrl_in.neg_q;
      ctrl_out.neg_r  <= ctrl_in.neg_r;
      side_out        <= side_in;
      rem_out         <= ge ? diff[W-1:0] : t[W-1:0];
      quo_out         <= {quo_in[W-2:0], ge};
      dsr_out         <= dsr_in;
    end
  end

endmodule

// ----- rtl/core/integer_alu_mul_div.sv -----
// Top level of the pipelined 64-bit integer ALU with multiply and divide.
// Depends on ialu_pkg, ialu_prep, ialu_mul and ialu_div_step.
//
// Usage:
//   The request channel (req_valid, req_stall, req_item) carries one item
//   per operation: two operands and an operation code. The response channel
//   (rsp_valid, rsp_stall, rsp_item) returns one item per request, in order,
//   holding the result and a status (ok, division by zero, invalid code).
//   Every operation passes through the same stages: one setup stage,
//   DATA_WIDTH restoring divider stages (one quotient bit each) and the
//   output register. The multiplier runs beside the first divider stages
//   and its result joins the common stream once its last register is loaded.
//   Throughput is one item per cycle while the receiver does not stall; the divider chain sets the depth.
//   When the receiver stalls while a response is waiting, the whole
//   pipeline holds and req_stall is raised in the same cycle; nothing is
//   dropped or repeated. A synchronous reset empties the pipeline by
//   clearing every stage's valid bit; payload registers keep their values.
//   Operand bits above DATA_WIDTH are ignored and results are zero-extended.
module integer_alu_mul_div import ialu_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_item
);

  localparam int W = DATA_WIDTH;
  // The multiplier result is registered three times after the setup stage.
  localparam int MUL_LAT = 3;

  logic en;

  ctrl_t        lvl_ctrl [0:W];
  logic [W-1:0] lvl_side [0:W];
  logic [W-1:0] lvl_rem  [0:W];
  logic [W-1:0] lvl_quo  [0:W];
  logic [W-1:0] lvl_dsr  [0:W];

  logic [W-1:0] op_a, op_b, mul_res, res_w, q_fix, r_fix;
  ctrl_t        out_ctrl;

  // The pipeline moves as a whole unless a finished response is waiting
  // on a stalled receiver.
  assign en        = ~(out_ctrl.valid & rsp_stall);
  assign req_stall = ~en;
  assign rsp_valid = out_ctrl.valid;

  ialu_prep #(.W(W)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid    (req_valid),
    .req_item (req_item),
    .ctrl     (lvl_ctrl[0]),
    .a_out    (op_a),
    .b_out    (op_b),
    .side     (lvl_side[0]),
    .dvd      (lvl_quo[0]),
    .dsr      (lvl_dsr[0])
  );

  assign lvl_rem[0] = '0;

  ialu_mul #(.W(W)) u_mul (
    .clk    (clk),
    .en     (en),
    .op     (lvl_ctrl[0].op),
    .a      (op_a),
    .b      (op_b),
    .result (mul_res)
  );

  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W-1:0] side_in;
    if (k == MUL_LAT + 1) begin : g_join
      // Multiply results replace the side value once they are ready.
      always_comb begin
        side_in = lvl_side[k-1];
        if (lvl_ctrl[k-1].op == OP_MUL || lvl_ctrl[k-1].op == OP_MULH ||
            lvl_ctrl[k-1].op == OP_MULHU) begin
          side_in = mul_res;
        end
      end
    end else begin : g_pass
      assign side_in = lvl_side[k-1];
    end

    ialu_div_step #(.W(W)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (lvl_ctrl[k-1]),
      .side_in  (side_in),
      .rem_in   (lvl_rem[k-1]),
      .quo_in   (lvl_quo[k-1]),
      .dsr_in   (lvl_dsr[k-1]),
      .ctrl_out (lvl_ctrl[k]),
      .side_out (lvl_side[k]),
      .rem_out  (lvl_rem[k]),
      .quo_out  (lvl_quo[k]),
      .dsr_out  (lvl_dsr[k])
    );
  end

  // Sign correction of quotient and remainder, then the result select.
  // Any status other than ok forces a zero result.
  always_comb begin
    q_fix = lvl_ctrl[W].neg_q ? (~lvl_quo[W] + 1'b1) : lvl_quo[W];
    r_fix = lvl_ctrl[W].neg_r ? (~lvl_rem[W] + 1'b1) : lvl_rem[W];
    case (lvl_ctrl[W].op) inside
      OP_DIV, OP_DIVU: res_w = q_fix;
      OP_REM, OP_REMU: res_w = r_fix;
      default:         res_w = lvl_side[W];
    endcase
    if (lvl_ctrl[W].status != ST_OK) res_w = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl.valid <= 1'b0;
    end else if (en) begin
      out_ctrl.valid <= lvl_ctrl[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl.op          <= lvl_ctrl[W].op;
      out_ctrl.status      <= lvl_ctrl[W].status;
      out_ctrl.neg_q       <= lvl_ctrl[W].neg_q;
      out_ctrl.neg_r       <= lvl_ctrl[W].neg_r;
      rsp_item.result_value <= 64'(res_w);
      rsp_item.status       <= lvl_ctrl[W].status;
    end
  end

`ifndef SYNTH
  // A response with a failing status always carries a zero result.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.status != ST_OK |-> rsp_item.result_value == 64'd0)
    else $error("nonzero result with error status");

  // The last divider stage leaves a remainder below the divisor.
  a_rem_below_dsr: assert property (@(posedge clk) disable iff (rst)
    lvl_ctrl[W].valid && lvl_ctrl[W].status == ST_OK &&
    (lvl_ctrl[W].op == OP_DIV || lvl_ctrl[W].op == OP_DIVU ||
     lvl_ctrl[W].op == OP_REM || lvl_ctrl[W].op == OP_REMU)
    |-> lvl_rem[W] < lvl_dsr[W])
    else $error("divider remainder not below divisor");

  // Division by zero is flagged only for the divide and remainder codes.
  a_div0_code: assert property (@(posedge clk) disable iff (rst)
    lvl_ctrl[0].valid && lvl_ctrl[0].status == ST_DIV0 |->
    (lvl_ctrl[0].op == OP_DIV || lvl_ctrl[0].op == OP_DIVU ||
     lvl_ctrl[0].op == OP_REM || lvl_ctrl[0].op == OP_REMU))
    else $error("division by zero flagged for other code");

  // A held pipeline keeps its response in place.
  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_ctrl) && $stable(lvl_ctrl[W]))
    else $error("pipeline moved while held");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking bench for the pipelined integer ALU with multiply and divide.
// Depends on ialu_pkg and the integer_alu_mul_div RTL; reads and writes no files.
// Holds a result scoreboard class, the stimulus tasks and the top module.

class alu_scoreboard;
  ialu_pkg::rsp_item_t pending_results[$];
  int unsigned fail_count;

  function new();
    fail_count = 0;
  endfunction

  // Computes the expected result of one request item.
  function ialu_pkg::rsp_item_t compute_result(ialu_pkg::req_item_t req);
    logic [63:0] a, b, qa, qb, qq, qr;
    logic [127:0] prod_u;
    logic signed [127:0] prod_s;
    logic [5:0] amt;
    ialu_pkg::rsp_item_t res;
    a = req.operand_a;
    b = req.operand_b;
    amt = b[5:0];
    res.status = ialu_pkg::ST_OK;
    res.result_value = '0;
    case (req.req_type)
      ialu_pkg::OP_ADD: res.result_value = a + b;
      ialu_pkg::OP_SUB: res.result_value = a - b;
      ialu_pkg::OP_MUL: res.result_value = a * b;
      ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
        if (b == 0) begin
          res.status = ialu_pkg::ST_DIV0;
        end else begin
          // Work on magnitudes so the most negative value needs no special path.
          qa = a[63] ? -a : a;
          qb = b[63] ? -b : b;
          qq = qa / qb;
          qr = qa % qb;
          if (req.req_type == ialu_pkg::OP_DIV) begin
            res.result_value = (a[63] != b[63]) ? -qq : qq;
          end else begin
            res.result_value = a[63] ? -qr : qr;
          end
        end
      end
      ialu_pkg::OP_DIVU: begin
        if (b == 0) res.status = ialu_pkg::ST_DIV0;
        else res.result_value = a / b;
      end
      ialu_pkg::OP_REMU: begin
        if (b == 0) res.status = ialu_pkg::ST_DIV0;
        else res.result_value = a % b;
      end
      ialu_pkg::OP_AND: res.result_value = a & b;
      ialu_pkg::OP_OR:  res.result_value = a | b;
      ialu_pkg::OP_XOR: res.result_value = a ^ b;
      ialu_pkg::OP_NOR: res.result_value = ~(a | b);
      ialu_pkg::OP_SLL: res.result_value = a << amt;
      ialu_pkg::OP_SRL: res.result_value = a >> amt;
      ialu_pkg::OP_SRA: res.result_value = $signed(a) >>> amt;
      ialu_pkg::OP_SLT: res.result_value = {63'd0, $signed(a) < $signed(b)};
      ialu_pkg::OP_SLTU: res.result_value = {63'd0, a < b};
      ialu_pkg::OP_MOV: res.result_value = a;
      ialu_pkg::OP_MULH: begin
        prod_s = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        res.result_value = prod_s[127:64];
      end
      ialu_pkg::OP_MULHU: begin
        prod_u = {64'd0, a} * {64'd0, b};
        res.result_value = prod_u[127:64];
      end
      default: res.status = ialu_pkg::ST_INVALID;
    endcase
    return res;
  endfunction

  function void note_request(ialu_pkg::req_item_t req);
    pending_results.push_back(compute_result(req));
  endfunction

  task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  task check_result(ialu_pkg::rsp_item_t got);
    ialu_pkg::rsp_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result", got.result_value, 64'd0);
      return;
    end
    want = pending_results.pop_front();
    if (got.result_value !== want.result_value)
      report_mismatch("result_value", got.result_value, want.result_value);
    if (got.status !== want.status)
      report_mismatch("status", {62'd0, got.status}, {62'd0, want.status});
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ialu_pkg::*;

  localparam int LATENCY = 66;
  localparam int RANDOM_ITEMS = 2000;
  localparam longint CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_item_t req_item = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  // The sink idles at random except during the calm window.
  bit calm = 1'b0;
  longint cycle_count = 0;
  alu_scoreboard results = new();

  integer_alu_mul_div u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
  );

  always #1 clk = ~clk;

  // Timeout watchdog; a correct run ends long before this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Accepted items are sampled at the rising edge. Requests are noted
  // before results are checked so a result beside its own request would still match.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) results.note_request(req_item);
    if (!rst && rsp_valid && !rsp_stall) results.check_result(rsp_item);
  end

  // Response stall is changed on the falling edge; outside the calm window it is raised with a chance of 35 in 100.
  always @(negedge clk) begin
    rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);
  end

  // Drives one item and holds it until the block takes it. Outside the calm
  // window the valid may first be lowered for random idle gaps.
  task automatic send_item(logic [63:0] a, logic [63:0] b, logic [4:0] op);
    bit accepted;
    while (!calm && $urandom_range(99) < 35) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item <= '{operand_a: a, operand_b: b, req_type: op};
    accepted = 1'b0;
    while (!accepted) begin
      @(posedge clk);
      accepted = !req_stall;
      @(negedge clk);
    end
  endtask

  // Operands biased toward edge values so overflow and sign cases show up.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return {64{1'b1}};
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'($urandom_range(130));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Lowers valid and waits for every result.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (results.pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [4:0] op;
    logic [63:0] b;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every code, extremes, zero divisor, most negative over -1,
    // shift amounts that only use the low six bits.
    for (int k = 0; k < 19; k++) begin
      send_item(64'h8000_0000_0000_0000, {64{1'b1}}, 5'(k));
    end
    send_item({64{1'b1}}, 64'd0, OP_DIV);
    send_item(64'd5, 64'd0, OP_REMU);
    send_item(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FF7F, OP_SRA);
    send_item(64'hFFFF_FFFF_FFFF_FFF9, 64'd2, OP_REM);
    send_item(64'd1, 64'd0, 5'd31);
    send_item(64'd0, 64'd0, 5'd19);

    // The sender holds off until every result is in.
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 800 && n < 1000);
      if (n == 1400) wait_drained();
      // Mostly valid codes, some invalid ones.
      op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
      b = pick_operand();
      if ((op == OP_SLL || op == OP_SRL || op == OP_SRA) && $urandom_range(1))
        b = {$urandom, 26'($urandom), 6'($urandom_range(63))};
      send_item(pick_operand(), b, op);
    end
    calm = 1'b0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    if (results.fail_count == 0 && results.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
